>>> hdl/tbp_pkg.sv
// ----------------------------------------------------------------------------
// tbp_pkg: shared types and constants of the timed button pulse controller
// Command kinds, result codes, ring sizing and the ring request/response beats.
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

    // Ring of recent sequence ids
    localparam int RECENT_DEPTH = 16;
    localparam int RING_IDX_W   = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;

    // All buttons released (active low)
    localparam logic [11:0] NEUTRAL_WORD = 12'hFFF;

    // Configuration register indexes
    localparam logic [1:0] REG_MIN_HOLD   = 2'd0;
    localparam logic [1:0] REG_MAX_HOLD   = 2'd1;
    localparam logic [1:0] REG_MAX_SETTLE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] MIN_HOLD_RST   = 16'd20;
    localparam logic [15:0] MAX_HOLD_RST   = 16'd2000;
    localparam logic [15:0] MAX_SETTLE_RST = 16'd2000;

    // Command kinds
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_PULSE   = 3'd1;
    localparam logic [2:0] KIND_STATUS  = 3'd2;
    localparam logic [2:0] KIND_RELEASE = 3'd3;
    localparam logic [2:0] KIND_ARM     = 3'd4;
    localparam logic [2:0] KIND_DISARM  = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_BUSY      = 3'd2;
    localparam logic [2:0] ST_NOT_ARMED = 3'd3;
    localparam logic [2:0] ST_NO_GAME   = 3'd4;

    // Pulse states
    localparam logic [2:0] PS_IDLE      = 3'd0;
    localparam logic [2:0] PS_ACCEPTED  = 3'd1;
    localparam logic [2:0] PS_IN_PROG   = 3'd2;
    localparam logic [2:0] PS_COMPLETED = 3'd3;
    localparam logic [2:0] PS_ALREADY   = 3'd4;
    localparam logic [2:0] PS_ABORTED   = 3'd5;
    localparam logic [2:0] PS_NOT_FOUND = 3'd6;

    // Ring lookup / record request
    typedef struct packed {
        logic        valid;
        logic        record;
        logic [31:0] key;
        logic [2:0]  outcome;
    } ring_req_t;

    // Ring completion beat
    typedef struct packed {
        logic       done;
        logic       hit;
        logic [2:0] outcome;
    } ring_rsp_t;

endpackage

`default_nettype wire

>>> hdl/tbp_ring.sv
// ----------------------------------------------------------------------------
// tbp_ring: ring of recent pulse sequence ids and their outcomes
// Scans one entry per cycle through a single 32-bit comparator. A find
// reports hit and outcome; a record then updates the hit entry in place or
// writes the oldest slot.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_ring
    import tbp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ring_req_t req,
    output      ring_rsp_t rsp
);

    typedef enum logic [2:0] {
        R_IDLE  = 3'b001,
        R_SCAN  = 3'b010,
        R_WRITE = 3'b100
    } ring_state_t;

    localparam logic [RING_IDX_W-1:0] IDX_LAST = RING_IDX_W'(RECENT_DEPTH - 1);

    ring_state_t              state_reg,   state_next;
    logic [RING_IDX_W-1:0]    idx_reg,     idx_next;
    logic [RING_IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [RING_IDX_W-1:0]    slot_reg,    slot_next;
    logic [31:0]              key_reg,     key_next;
    logic [2:0]               outc_reg,    outc_next;
    logic                     rec_reg,     rec_next;
    logic                     hit_reg,     hit_next;
    logic [2:0]               hit_out_reg, hit_out_next;
    logic                     done_reg,    done_next;

    logic [31:0]              ids_reg  [RECENT_DEPTH];
    logic [2:0]               outs_reg [RECENT_DEPTH];

    logic                     wr_en;
    logic                     wr_id;
    logic [RING_IDX_W-1:0]    wr_idx;
    logic                     match;

    // Shared compare of the scanned entry
    assign match = (ids_reg[idx_reg] == key_reg);

    // Sequence the scan and the write-back
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        hit_idx_next = hit_idx_reg;
        slot_next    = slot_reg;
        key_next     = key_reg;
        outc_next    = outc_reg;
        rec_next     = rec_reg;
        hit_next     = hit_reg;
        hit_out_next = hit_out_reg;
        done_next    = 1'b0;
        wr_en        = 1'b0;
        wr_id        = 1'b0;
        wr_idx       = slot_reg;

        case (state_reg)
            R_IDLE:
            begin
                if (req.valid)
                begin
                    key_next   = req.key;
                    outc_next  = req.outcome;
                    rec_next   = req.record;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = R_SCAN;
                end
            end
            R_SCAN:
            begin
                if (match || idx_reg == IDX_LAST)
                begin
                    hit_next     = match;
                    hit_idx_next = idx_reg;
                    hit_out_next = outs_reg[idx_reg];
                    if (rec_reg)
                    begin
                        state_next = R_WRITE;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = R_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            R_WRITE:
            begin
                wr_en = 1'b1;
                if (hit_reg)
                begin
                    wr_idx = hit_idx_reg;
                end
                else
                begin
                    wr_id     = 1'b1;
                    wr_idx    = slot_reg;
                    slot_next = (slot_reg == IDX_LAST) ? '0 : slot_reg + 1'b1;
                end
                done_next  = 1'b1;
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            slot_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            done_reg  <= done_next;
        end
    end

    // Hold scan payload
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        hit_idx_reg <= hit_idx_next;
        key_reg     <= key_next;
        outc_reg    <= outc_next;
        rec_reg     <= rec_next;
        hit_reg     <= hit_next;
        hit_out_reg <= hit_out_next;
    end

    // Ring storage, empty after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RECENT_DEPTH; i++)
            begin
                ids_reg[i]  <= '0;
                outs_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            outs_reg[wr_idx] <= outc_reg;
            if (wr_id)
            begin
                ids_reg[wr_idx] <= key_reg;
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.hit     = hit_reg;
    assign rsp.outcome = hit_out_reg;

    // A request is only issued while the ring is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> state_reg == R_IDLE)
        else $error("ring request while scan in progress");

    // Completion is a single-cycle beat
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("ring done held longer than one cycle");

endmodule

`default_nettype wire

>>> hdl/timed_button_pulse_controller.sv
// ----------------------------------------------------------------------------
// timed_button_pulse_controller: timed active-low button pulse driver
// Takes tick, pulse, status, release, arm and disarm commands, drives the
// 12-bit button word and answers each command with one status beat.
// ----------------------------------------------------------------------------
// Sequence: an accepted command runs T_SVC0, T_ACT and T_DONE (a tick adds T_SVC1),
//   and the strobe is registered from T_DONE; a record pass waits in T_RWAIT, a find
//   in T_FWAIT, so a completion record followed by a find is the worst case.
// Commands: one at a time, paced by the one-entry-per-cycle ring scan; the
//   next command is taken at the edge that ends the strobe.
// Reset: disarmed, idle, buttons released, ring empty, limits 20/2000/2000; no stall.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_button_pulse_controller
    import tbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] seq_id,
    input  wire logic [31:0] button_word,
    input  wire logic [15:0] hold_ms,
    input  wire logic [15:0] settle_ms,
    input  wire logic        game_ready,
    // configuration channel
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // result channel
    output      logic        result_valid,
    output      logic [2:0]  status,
    output      logic [31:0] seq_out,
    output      logic [2:0]  pulse_state,
    output      logic [11:0] buttons,
    output      logic [15:0] remaining_ms,
    output      logic        pulse_active,
    output      logic        armed_flag
);

    typedef enum logic [6:0] {
        T_IDLE  = 7'b0000001,
        T_SVC0  = 7'b0000010,
        T_ACT   = 7'b0000100,
        T_SVC1  = 7'b0001000,
        T_RWAIT = 7'b0010000,
        T_FWAIT = 7'b0100000,
        T_DONE  = 7'b1000000
    } ctl_state_t;

    ctl_state_t  state_reg,      state_next;
    logic        ret_act_reg,    ret_act_next;

    // latched command
    logic [2:0]  kind_reg,       kind_next;
    logic [31:0] seq_reg,        seq_next;
    logic [31:0] word_reg,       word_next;
    logic [15:0] hold_reg,       hold_next;
    logic [15:0] settle_in_reg,  settle_in_next;
    logic        ready_reg,      ready_next;

    // pulse state
    logic        armed_reg,      armed_next;
    logic        active_reg,     active_next;
    logic        settling_reg,   settling_next;
    logic [31:0] cur_seq_reg,    cur_seq_next;
    logic [11:0] drive_reg,      drive_next;
    logic [15:0] settle_len_reg, settle_len_next;
    logic [15:0] time_left_reg,  time_left_next;

    // pending result codes
    logic [2:0]  res_status_reg, res_status_next;
    logic [31:0] res_seq_reg,    res_seq_next;
    logic [2:0]  res_state_reg,  res_state_next;

    // result beat
    logic        out_valid_reg,  out_valid_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic [31:0] out_seq_reg,    out_seq_next;
    logic [2:0]  out_state_reg,  out_state_next;
    logic [11:0] out_btn_reg,    out_btn_next;
    logic [15:0] out_rem_reg,    out_rem_next;
    logic        out_act_reg,    out_act_next;
    logic        out_arm_reg,    out_arm_next;

    // configuration
    logic [15:0] min_hold_reg;
    logic [15:0] max_hold_reg;
    logic [15:0] max_settle_reg;

    ring_req_t   ring_req;
    ring_rsp_t   ring_rsp;

    logic        pulse_bad;
    logic        accept;

    assign accept = start && (state_reg == T_IDLE);

    // Reject malformed pulse requests
    assign pulse_bad = (seq_reg == 32'd0) || (word_reg[31:12] != 20'd0)
                    || (word_reg[11:0] == NEUTRAL_WORD)
                    || (hold_reg < min_hold_reg) || (hold_reg > max_hold_reg)
                    || (settle_in_reg > max_settle_reg);

    tbp_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ring_req),
        .rsp   (ring_rsp)
    );

    // Command sequencer
    always_comb
    begin
        state_next      = state_reg;
        ret_act_next    = ret_act_reg;
        kind_next       = kind_reg;
        seq_next        = seq_reg;
        word_next       = word_reg;
        hold_next       = hold_reg;
        settle_in_next  = settle_in_reg;
        ready_next      = ready_reg;
        armed_next      = armed_reg;
        active_next     = active_reg;
        settling_next   = settling_reg;
        cur_seq_next    = cur_seq_reg;
        drive_next      = drive_reg;
        settle_len_next = settle_len_reg;
        time_left_next  = time_left_reg;
        res_status_next = res_status_reg;
        res_seq_next    = res_seq_reg;
        res_state_next  = res_state_reg;
        out_valid_next  = 1'b0;
        out_status_next = out_status_reg;
        out_seq_next    = out_seq_reg;
        out_state_next  = out_state_reg;
        out_btn_next    = out_btn_reg;
        out_rem_next    = out_rem_reg;
        out_act_next    = out_act_reg;
        out_arm_next    = out_arm_reg;
        ring_req        = '0;

        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    kind_next      = kind;
                    seq_next       = seq_id;
                    word_next      = button_word;
                    hold_next      = hold_ms;
                    settle_in_next = settle_ms;
                    ready_next     = game_ready;
                    state_next     = T_SVC0;
                end
            end

            // Expire the hold or settle phase when its time has run out
            T_SVC0, T_SVC1:
            begin
                ret_act_next = (state_reg == T_SVC0);
                state_next   = (state_reg == T_SVC0) ? T_ACT : T_DONE;
                if (active_reg && time_left_reg == 16'd0)
                begin
                    drive_next = NEUTRAL_WORD;
                    if (!settling_reg && settle_len_reg != 16'd0)
                    begin
                        settling_next  = 1'b1;
                        time_left_next = settle_len_reg;
                    end
                    else
                    begin
                        active_next     = 1'b0;
                        settling_next   = 1'b0;
                        settle_len_next = '0;
                        time_left_next  = '0;
                        cur_seq_next    = '0;
                        if (cur_seq_reg != 32'd0)
                        begin
                            ring_req.valid   = 1'b1;
                            ring_req.record  = 1'b1;
                            ring_req.key     = cur_seq_reg;
                            ring_req.outcome = PS_COMPLETED;
                            state_next       = T_RWAIT;
                        end
                    end
                end
            end

            // Act on the command
            T_ACT:
            begin
                res_status_next = ST_OK;
                res_seq_next    = '0;
                res_state_next  = PS_IDLE;
                ret_act_next    = 1'b0;
                state_next      = T_DONE;
                case (kind_reg)
                    KIND_TICK:
                    begin
                        if (active_reg && time_left_reg != 16'd0)
                        begin
                            time_left_next = time_left_reg - 16'd1;
                        end
                        state_next = T_SVC1;
                    end
                    KIND_PULSE:
                    begin
                        res_seq_next = seq_reg;
                        if (!armed_reg)
                        begin
                            res_status_next = ST_NOT_ARMED;
                            res_state_next  = PS_ABORTED;
                        end
                        else if (pulse_bad)
                        begin
                            res_status_next = ST_INVALID;
                            res_state_next  = PS_ABORTED;
                        end
                        else if (active_reg && cur_seq_reg == seq_reg)
                        begin
                            res_state_next = PS_IN_PROG;
                        end
                        else
                        begin
                            ring_req.valid = 1'b1;
                            ring_req.key   = seq_reg;
                            state_next     = T_FWAIT;
                        end
                    end
                    KIND_STATUS:
                    begin
                        if (seq_reg == 32'd0)
                        begin
                            if (active_reg)
                            begin
                                res_seq_next   = cur_seq_reg;
                                res_state_next = PS_IN_PROG;
                            end
                        end
                        else if (active_reg && cur_seq_reg == seq_reg)
                        begin
                            res_seq_next   = seq_reg;
                            res_state_next = PS_IN_PROG;
                        end
                        else
                        begin
                            res_seq_next   = seq_reg;
                            ring_req.valid = 1'b1;
                            ring_req.key   = seq_reg;
                            state_next     = T_FWAIT;
                        end
                    end
                    KIND_RELEASE, KIND_DISARM:
                    begin
                        drive_next = NEUTRAL_WORD;
                        if (kind_reg == KIND_DISARM)
                        begin
                            armed_next = 1'b0;
                        end
                        if (active_reg)
                        begin
                            active_next     = 1'b0;
                            settling_next   = 1'b0;
                            settle_len_next = '0;
                            time_left_next  = '0;
                            cur_seq_next    = '0;
                            if (cur_seq_reg != 32'd0)
                            begin
                                ring_req.valid   = 1'b1;
                                ring_req.record  = 1'b1;
                                ring_req.key     = cur_seq_reg;
                                ring_req.outcome = PS_ABORTED;
                                state_next       = T_RWAIT;
                            end
                        end
                    end
                    KIND_ARM:
                    begin
                        if (!armed_reg)
                        begin
                            if (!ready_reg)
                            begin
                                res_status_next = ST_NO_GAME;
                                res_state_next  = PS_ABORTED;
                            end
                            else
                            begin
                                drive_next = NEUTRAL_WORD;
                                armed_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_INVALID;
                    end
                endcase
            end

            // Wait for the outcome write-back
            T_RWAIT:
            begin
                if (ring_rsp.done)
                begin
                    state_next = ret_act_reg ? T_ACT : T_DONE;
                end
            end

            // Decide from the ring lookup
            T_FWAIT:
            begin
                if (ring_rsp.done)
                begin
                    state_next = T_DONE;
                    if (kind_reg == KIND_PULSE)
                    begin
                        if (ring_rsp.hit)
                        begin
                            res_state_next = (ring_rsp.outcome == PS_COMPLETED)
                                             ? PS_ALREADY : ring_rsp.outcome;
                        end
                        else if (active_reg)
                        begin
                            res_status_next = ST_BUSY;
                            res_seq_next    = cur_seq_reg;
                            res_state_next  = PS_IN_PROG;
                        end
                        else
                        begin
                            drive_next      = word_reg[11:0];
                            active_next     = 1'b1;
                            settling_next   = 1'b0;
                            cur_seq_next    = seq_reg;
                            settle_len_next = settle_in_reg;
                            time_left_next  = hold_reg;
                            res_state_next  = PS_ACCEPTED;
                        end
                    end
                    else
                    begin
                        res_state_next = ring_rsp.hit ? ring_rsp.outcome : PS_NOT_FOUND;
                    end
                end
            end

            // Drive the result beat
            T_DONE:
            begin
                out_valid_next = 1'b1;
                out_btn_next   = drive_reg;
                out_rem_next   = active_reg ? time_left_reg : 16'd0;
                out_act_next   = active_reg;
                out_arm_next   = armed_reg;
                if (kind_reg == KIND_TICK)
                begin
                    out_status_next = ST_OK;
                    out_seq_next    = active_reg ? cur_seq_reg : 32'd0;
                    out_state_next  = active_reg ? PS_IN_PROG : PS_IDLE;
                end
                else
                begin
                    out_status_next = res_status_reg;
                    out_seq_next    = res_seq_reg;
                    out_state_next  = res_state_reg;
                end
                state_next = T_IDLE;
            end

            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Hold control and pulse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            ret_act_reg    <= 1'b0;
            armed_reg      <= 1'b0;
            active_reg     <= 1'b0;
            settling_reg   <= 1'b0;
            cur_seq_reg    <= '0;
            drive_reg      <= NEUTRAL_WORD;
            settle_len_reg <= '0;
            time_left_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_act_reg    <= ret_act_next;
            armed_reg      <= armed_next;
            active_reg     <= active_next;
            settling_reg   <= settling_next;
            cur_seq_reg    <= cur_seq_next;
            drive_reg      <= drive_next;
            settle_len_reg <= settle_len_next;
            time_left_reg  <= time_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold command and result payload
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        seq_reg        <= seq_next;
        word_reg       <= word_next;
        hold_reg       <= hold_next;
        settle_in_reg  <= settle_in_next;
        ready_reg      <= ready_next;
        res_status_reg <= res_status_next;
        res_seq_reg    <= res_seq_next;
        res_state_reg  <= res_state_next;
        out_status_reg <= out_status_next;
        out_seq_reg    <= out_seq_next;
        out_state_reg  <= out_state_next;
        out_btn_reg    <= out_btn_next;
        out_rem_reg    <= out_rem_next;
        out_act_reg    <= out_act_next;
        out_arm_reg    <= out_arm_next;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_hold_reg   <= MIN_HOLD_RST;
            max_hold_reg   <= MAX_HOLD_RST;
            max_settle_reg <= MAX_SETTLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MIN_HOLD:   min_hold_reg   <= cfg_data;
                REG_MAX_HOLD:   max_hold_reg   <= cfg_data;
                REG_MAX_SETTLE: max_settle_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg_ready    = 1'b1;
    assign busy         = (state_reg != T_IDLE);
    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign seq_out      = out_seq_reg;
    assign pulse_state  = out_state_reg;
    assign buttons      = out_btn_reg;
    assign remaining_ms = out_rem_reg;
    assign pulse_active = out_act_reg;
    assign armed_flag   = out_arm_reg;

    // An accepted command raises busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // One result beat per command
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // An idle pulse carries no timing
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (time_left_reg == 16'd0) && !settling_reg)
        else $error("timer or settle flag left over with no pulse");

    // A pulse only runs while armed
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> armed_reg)
        else $error("pulse active while disarmed");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the timed button pulse controller
// Walks a short table of directed commands, then several phases of random
// command traffic under different hold/settle limits. Every accepted command
// is run through a local model of the pulse engine and its ring of recent ids;
// every result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top
    import tbp_pkg::*;
();

    // Kinds the block does not define
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_WAIT       = 4 + 2 * (RECENT_DEPTH + 2);
    localparam int MAX_GAP        = 16;
    localparam int PHASE_ITEMS    = 380;
    localparam int NUM_PHASES     = 5;

    // One command beat, with an optional hand-typed expectation
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] seq;
        logic [31:0] word;
        logic [15:0] hold;
        logic [15:0] settle;
        logic        ready;
        logic        typed;
        logic [2:0]  t_status;
        logic [31:0] t_seq;
        logic [2:0]  t_state;
    } cmd_t;

    // One result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] seq;
        logic [2:0]  pstate;
        logic [11:0] buttons;
        logic [15:0] remaining;
        logic        active;
        logic        armed;
        logic [31:0] idx;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cur_cmd;
    logic [2:0]  kind;
    logic [31:0] seq_id;
    logic [31:0] button_word;
    logic [15:0] hold_ms;
    logic [15:0] settle_ms;
    logic        game_ready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        result_valid;
    logic [2:0]  status;
    logic [31:0] seq_out;
    logic [2:0]  pulse_state;
    logic [11:0] buttons;
    logic [15:0] remaining_ms;
    logic        pulse_active;
    logic        armed_flag;

    assign kind        = cur_cmd.kind;
    assign seq_id      = cur_cmd.seq;
    assign button_word = cur_cmd.word;
    assign hold_ms     = cur_cmd.hold;
    assign settle_ms   = cur_cmd.settle;
    assign game_ready  = cur_cmd.ready;

    timed_button_pulse_controller i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .seq_id       (seq_id),
        .button_word  (button_word),
        .hold_ms      (hold_ms),
        .settle_ms    (settle_ms),
        .game_ready   (game_ready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status       (status),
        .seq_out      (seq_out),
        .pulse_state  (pulse_state),
        .buttons      (buttons),
        .remaining_ms (remaining_ms),
        .pulse_active (pulse_active),
        .armed_flag   (armed_flag)
    );

    // Free-running clock, 8 ns
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Pulse engine model: limits, pulse state and ring of recent ids
    // ------------------------------------------------------------------
    logic [15:0] lim_min;
    logic [15:0] lim_max;
    logic [15:0] lim_settle;
    logic        pr_armed;
    logic        pr_active;
    logic        pr_settling;
    logic [31:0] pr_cur_seq;
    logic [11:0] pr_drive;
    logic [15:0] pr_settle_len;
    logic [15:0] pr_time_left;
    logic [31:0] ring_ids  [RECENT_DEPTH];
    logic [2:0]  ring_outc [RECENT_DEPTH];
    logic [RING_IDX_W-1:0] ring_next;

    reply_t pending_replies [$];
    int     n_cmds;
    int     n_cfg;
    int     n_errors;
    int     n_started;
    int     n_completed;
    int     n_aborted;
    logic   gaps_on;

    task automatic clear_pulse_model();
        begin
            lim_min       = MIN_HOLD_RST;
            lim_max       = MAX_HOLD_RST;
            lim_settle    = MAX_SETTLE_RST;
            pr_armed      = 1'b0;
            pr_active     = 1'b0;
            pr_settling   = 1'b0;
            pr_cur_seq    = '0;
            pr_drive      = NEUTRAL_WORD;
            pr_settle_len = '0;
            pr_time_left  = '0;
            ring_next     = '0;
            for (int i = 0; i < RECENT_DEPTH; i++)
            begin
                ring_ids[i]  = '0;
                ring_outc[i] = '0;
            end
        end
    endtask

    function automatic int ring_lookup(input logic [31:0] id);
        int hit;
        begin
            hit = -1;
            for (int i = RECENT_DEPTH - 1; i >= 0; i--)
                if (ring_ids[i] == id)
                    hit = i;
            return hit;
        end
    endfunction

    task automatic ring_store(input logic [31:0] id, input logic [2:0] outc);
        int hit;
        begin
            hit = ring_lookup(id);
            if (id != 32'd0)
            begin
                if (hit >= 0)
                    ring_outc[hit] = outc;
                else
                begin
                    ring_ids[ring_next]  = id;
                    ring_outc[ring_next] = outc;
                    ring_next            = ring_next + 1'b1;
                end
            end
        end
    endtask

    task automatic close_pulse(input logic [2:0] outc);
        logic [31:0] id;
        begin
            id            = pr_cur_seq;
            pr_drive      = NEUTRAL_WORD;
            pr_active     = 1'b0;
            pr_settling   = 1'b0;
            pr_settle_len = '0;
            pr_time_left  = '0;
            pr_cur_seq    = '0;
            ring_store(id, outc);
            if (outc == PS_COMPLETED)
                n_completed++;
            else
                n_aborted++;
        end
    endtask

    // Expire a hold or settle phase whose time has run out
    task automatic expire_phase();
        begin
            if (pr_active && pr_time_left == 16'd0)
            begin
                if (!pr_settling)
                begin
                    pr_drive    = NEUTRAL_WORD;
                    pr_settling = 1'b1;
                    if (pr_settle_len == 16'd0)
                        close_pulse(PS_COMPLETED);
                    else
                        pr_time_left = pr_settle_len;
                end
                else
                    close_pulse(PS_COMPLETED);
            end
        end
    endtask

    function automatic reply_t make_reply(input logic [2:0] st, input logic [31:0] sq,
                                          input logic [2:0] ps);
        reply_t r;
        begin
            r.status    = st;
            r.seq       = sq;
            r.pstate    = ps;
            r.buttons   = pr_drive;
            r.remaining = pr_active ? pr_time_left : 16'd0;
            r.active    = pr_active;
            r.armed     = pr_armed;
            r.idx       = '0;
            return r;
        end
    endfunction

    task automatic compute_pulse_reply(input cmd_t c, output reply_t r);
        int  hit;
        logic bad;
        begin
            expire_phase();
            bad = (c.seq == 32'd0) || (c.word[31:12] != 20'd0) ||
                  (c.word[11:0] == NEUTRAL_WORD) ||
                  (c.hold < lim_min) || (c.hold > lim_max) || (c.settle > lim_settle);
            case (c.kind)
                KIND_TICK:
                begin
                    if (pr_active && pr_time_left > 16'd0)
                        pr_time_left = pr_time_left - 1'b1;
                    expire_phase();
                    r = pr_active ? make_reply(ST_OK, pr_cur_seq, PS_IN_PROG)
                                  : make_reply(ST_OK, '0, PS_IDLE);
                end
                KIND_PULSE:
                begin
                    hit = ring_lookup(c.seq);
                    if (!pr_armed)
                        r = make_reply(ST_NOT_ARMED, c.seq, PS_ABORTED);
                    else if (bad)
                        r = make_reply(ST_INVALID, c.seq, PS_ABORTED);
                    else if (pr_active && pr_cur_seq == c.seq)
                        r = make_reply(ST_OK, c.seq, PS_IN_PROG);
                    else if (hit >= 0)
                        r = make_reply(ST_OK, c.seq, (ring_outc[hit] == PS_COMPLETED) ?
                                                     PS_ALREADY : ring_outc[hit]);
                    else if (pr_active)
                        r = make_reply(ST_BUSY, pr_cur_seq, PS_IN_PROG);
                    else
                    begin
                        pr_drive      = c.word[11:0];
                        pr_active     = 1'b1;
                        pr_settling   = 1'b0;
                        pr_cur_seq    = c.seq;
                        pr_settle_len = c.settle;
                        pr_time_left  = c.hold;
                        n_started++;
                        r = make_reply(ST_OK, c.seq, PS_ACCEPTED);
                    end
                end
                KIND_STATUS:
                begin
                    hit = ring_lookup(c.seq);
                    if (c.seq == 32'd0)
                        r = pr_active ? make_reply(ST_OK, pr_cur_seq, PS_IN_PROG)
                                      : make_reply(ST_OK, '0, PS_IDLE);
                    else if (pr_active && pr_cur_seq == c.seq)
                        r = make_reply(ST_OK, c.seq, PS_IN_PROG);
                    else if (hit >= 0)
                        r = make_reply(ST_OK, c.seq, ring_outc[hit]);
                    else
                        r = make_reply(ST_OK, c.seq, PS_NOT_FOUND);
                end
                KIND_RELEASE, KIND_DISARM:
                begin
                    if (pr_active)
                        close_pulse(PS_ABORTED);
                    pr_drive = NEUTRAL_WORD;
                    if (c.kind == KIND_DISARM)
                        pr_armed = 1'b0;
                    r = make_reply(ST_OK, '0, PS_IDLE);
                end
                KIND_ARM:
                begin
                    if (pr_armed)
                        r = make_reply(ST_OK, '0, PS_IDLE);
                    else if (!c.ready)
                        r = make_reply(ST_NO_GAME, '0, PS_ABORTED);
                    else
                    begin
                        pr_drive = NEUTRAL_WORD;
                        pr_armed = 1'b1;
                        r = make_reply(ST_OK, '0, PS_IDLE);
                    end
                end
                default:
                    r = make_reply(ST_INVALID, '0, PS_IDLE);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: compare result beats, predict accepted commands, track writes
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] idx,
                               input logic [31:0] want, input logic [31:0] got);
        begin
            if (want !== got)
            begin
                $display("%0t: item %0d %s mismatch: expected %0h, actual %0h",
                         $time, idx, name, want, got);
                n_errors++;
            end
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        reply_t want;
        cmd_t   c;
        if (rst_n)
        begin
            // Check the result beat against the oldest prediction
            if (result_valid)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: status %0h seq %0h",
                             $time, status, seq_out);
                    n_errors++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    check_field("status", want.idx, 32'(want.status), 32'(status));
                    check_field("seq_out", want.idx, want.seq, seq_out);
                    check_field("pulse_state", want.idx, 32'(want.pstate),
                                32'(pulse_state));
                    check_field("buttons", want.idx, 32'(want.buttons), 32'(buttons));
                    check_field("remaining_ms", want.idx, 32'(want.remaining),
                                32'(remaining_ms));
                    check_field("pulse_active", want.idx, 32'(want.active),
                                32'(pulse_active));
                    check_field("armed_flag", want.idx, 32'(want.armed), 32'(armed_flag));
                end
            end
            // Predict the command beat taken at this edge
            if (start && !busy)
            begin
                c = cur_cmd;
                compute_pulse_reply(c, want);
                if (c.typed)
                begin
                    want.status = c.t_status;
                    want.seq    = c.t_seq;
                    want.pstate = c.t_state;
                end
                want.idx = 32'(n_cmds);
                pending_replies.push_back(want);
                n_cmds++;
            end
            // Mirror register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIN_HOLD:   lim_min    = cfg_data;
                    REG_MAX_HOLD:   lim_max    = cfg_data;
                    REG_MAX_SETTLE: lim_settle = cfg_data;
                    default: ;
                endcase
                n_cfg++;
            end
        end
    end

    // Watchdog: end the run after a long stretch with no beat on any channel
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n)
            quiet = 0;
        else if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic issue_cmd(input cmd_t c);
        int target;
        int gap;
        begin
            gap = 0;
            // Idle the command channel at random
            while (gaps_on && gap < MAX_GAP && $urandom_range(99) < 35)
            begin
                start <= 1'b0;
                @(negedge clk);
                gap++;
            end
            target = n_cmds + 1;
            cur_cmd <= c;
            start   <= 1'b1;
            do
                @(negedge clk);
            while (n_cmds < target);
        end
    endtask

    // Hold off commands until every expected result has come back
    task automatic drain_results();
        begin
            start <= 1'b0;
            @(negedge clk);
            while (pending_replies.size() != 0)
                @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        int target;
        int gap;
        begin
            gap = 0;
            // Idle the write channel at random
            while (gaps_on && gap < MAX_GAP && $urandom_range(99) < 35)
            begin
                cfg_valid <= 1'b0;
                @(negedge clk);
                gap++;
            end
            target = n_cfg + 1;
            cfg_index <= idx;
            cfg_data  <= data;
            cfg_valid <= 1'b1;
            do
                @(negedge clk);
            while (n_cfg < target);
        end
    endtask

    task automatic program_limits(input logic [15:0] mn, input logic [15:0] mx,
                                  input logic [15:0] st);
        begin
            drain_results();
            write_reg(REG_MIN_HOLD, mn);
            write_reg(REG_MAX_HOLD, mx);
            write_reg(REG_MAX_SETTLE, st);
            cfg_valid <= 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic cmd_t dir_item(input logic [2:0] k, input logic [31:0] sq,
                                      input logic [31:0] w, input logic [15:0] h,
                                      input logic [15:0] s, input logic rdy,
                                      input logic typed, input logic [2:0] ts,
                                      input logic [31:0] tq, input logic [2:0] tp);
        cmd_t c;
        begin
            c.kind     = k;
            c.seq      = sq;
            c.word     = w;
            c.hold     = h;
            c.settle   = s;
            c.ready    = rdy;
            c.typed    = typed;
            c.t_status = ts;
            c.t_seq    = tq;
            c.t_state  = tp;
            return c;
        end
    endfunction

    function automatic logic [31:0] pick_seq();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 80)
                return $urandom_range(40, 1);
            else if (r < 93)
                return $urandom;
            else
                return '0;
        end
    endfunction

    function automatic logic [15:0] pick_hold();
        int r;
        int lo;
        int hi;
        begin
            r  = $urandom_range(99);
            lo = int'(lim_min);
            hi = int'(lim_max);
            if (hi > lo + 12)
                hi = lo + 12;
            if (r < 88)
                return (lo > hi) ? lo[15:0] : 16'($urandom_range(hi, lo));
            else if (r < 94)
                return 16'($urandom_range(65535, 0));
            else if (r < 97)
                return lim_min - 1'b1;
            else
                return lim_max + 1'b1;
        end
    endfunction

    function automatic logic [15:0] pick_settle();
        int r;
        int hi;
        begin
            r  = $urandom_range(99);
            hi = (lim_settle > 16'd8) ? 8 : int'(lim_settle);
            if (r < 85)
                return 16'($urandom_range(hi, 0));
            else if (r < 92)
                return '0;
            else if (r < 96)
                return lim_settle + 1'b1;
            else
                return 16'($urandom_range(65535, 0));
        end
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 85)
                return {20'd0, 12'($urandom_range(4095, 0))};
            else if (r < 92)
                return {20'd0, NEUTRAL_WORD};
            else
                return $urandom;
        end
    endfunction

    task automatic gen_random_cmd(output cmd_t c);
        int r;
        begin
            // Start from noise on every field, then shape by kind
            c.seq    = $urandom;
            c.word   = $urandom;
            c.hold   = 16'($urandom_range(65535, 0));
            c.settle = 16'($urandom_range(65535, 0));
            c.ready  = 1'($urandom_range(1, 0));
            c.typed  = 1'b0;
            c.t_status = '0;
            c.t_seq    = '0;
            c.t_state  = '0;
            r = $urandom_range(99);
            if (r < 44)
                c.kind = KIND_TICK;
            else if (r < 70)
            begin
                c.kind   = KIND_PULSE;
                c.seq    = pick_seq();
                c.word   = pick_word();
                c.hold   = pick_hold();
                c.settle = pick_settle();
            end
            else if (r < 82)
            begin
                c.kind = KIND_STATUS;
                r = $urandom_range(99);
                if (r < 45)
                    c.seq = $urandom_range(40, 1);
                else if (r < 65)
                    c.seq = '0;
                else if (r < 80)
                    c.seq = pr_cur_seq;
            end
            else if (r < 86)
                c.kind = KIND_RELEASE;
            else if (r < 92)
            begin
                c.kind  = KIND_ARM;
                c.ready = ($urandom_range(99) < 70);
            end
            else if (r < 95)
                c.kind = KIND_DISARM;
            else if (r < 97)
                c.kind = KIND_SPARE6;
            else
                c.kind = KIND_SPARE7;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        cmd_t        dir_rows [$];
        cmd_t        c;
        logic [15:0] mn;
        logic [15:0] mx;
        logic [15:0] st;
        rst_n       = 1'b0;
        start       = 1'b0;
        cur_cmd     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        gaps_on     = 1'b1;
        n_cmds      = 0;
        n_cfg       = 0;
        n_errors    = 0;
        n_started   = 0;
        n_completed = 0;
        n_aborted   = 0;
        clear_pulse_model();

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table under reset limits
        dir_rows.push_back(dir_item(KIND_TICK, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0,
                                    1'b1, ST_OK, 32'd0, PS_IDLE));
        dir_rows.push_back(dir_item(KIND_STATUS, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0,
                                    1'b1, ST_OK, 32'd0, PS_IDLE));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'd5, 32'hFFE, 16'd20, 16'd0, 1'b0,
                                    1'b1, ST_NOT_ARMED, 32'd5, PS_ABORTED));
        dir_rows.push_back(dir_item(KIND_ARM, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0,
                                    1'b1, ST_NO_GAME, 32'd0, PS_ABORTED));
        dir_rows.push_back(dir_item(KIND_SPARE6, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0,
                                    1'b1, ST_INVALID, 32'd0, PS_IDLE));
        dir_rows.push_back(dir_item(KIND_SPARE7, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                                    16'hFFFF, 1'b1, 1'b1, ST_INVALID, 32'd0, PS_IDLE));
        dir_rows.push_back(dir_item(KIND_ARM, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1,
                                    1'b1, ST_OK, 32'd0, PS_IDLE));
        dir_rows.push_back(dir_item(KIND_ARM, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0,
                                    1'b1, ST_OK, 32'd0, PS_IDLE));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'd0, 32'hFFE, 16'd20, 16'd0, 1'b0,
                                    1'b1, ST_INVALID, 32'd0, PS_ABORTED));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'd7, 32'hFFFFF000, 16'd20, 16'd0, 1'b0,
                                    1'b1, ST_INVALID, 32'd7, PS_ABORTED));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'd7, 32'hFFF, 16'd20, 16'd0, 1'b0,
                                    1'b1, ST_INVALID, 32'd7, PS_ABORTED));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'd7, 32'h000, 16'd19, 16'd0, 1'b0,
                                    1'b1, ST_INVALID, 32'd7, PS_ABORTED));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'd7, 32'h000, 16'd2001, 16'd0, 1'b0,
                                    1'b1, ST_INVALID, 32'd7, PS_ABORTED));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'd7, 32'h000, 16'd20, 16'd2001, 1'b0,
                                    1'b1, ST_INVALID, 32'd7, PS_ABORTED));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'hFFFFFFFF, 32'h000, 16'd20, 16'd0, 1'b0,
                                    1'b1, ST_OK, 32'hFFFFFFFF, PS_ACCEPTED));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'hFFFFFFFF, 32'h000, 16'd20, 16'd0, 1'b0,
                                    1'b1, ST_OK, 32'hFFFFFFFF, PS_IN_PROG));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'd9, 32'h555, 16'd30, 16'd5, 1'b0,
                                    1'b1, ST_BUSY, 32'hFFFFFFFF, PS_IN_PROG));
        dir_rows.push_back(dir_item(KIND_STATUS, 32'hFFFFFFFF, 32'd0, 16'd0, 16'd0, 1'b0,
                                    1'b1, ST_OK, 32'hFFFFFFFF, PS_IN_PROG));
        dir_rows.push_back(dir_item(KIND_TICK, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0,
                                    1'b0, '0, '0, '0));
        dir_rows.push_back(dir_item(KIND_RELEASE, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0,
                                    1'b1, ST_OK, 32'd0, PS_IDLE));
        dir_rows.push_back(dir_item(KIND_STATUS, 32'hFFFFFFFF, 32'd0, 16'd0, 16'd0, 1'b0,
                                    1'b0, '0, '0, '0));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'hFFFFFFFF, 32'h000, 16'd20, 16'd0, 1'b0,
                                    1'b0, '0, '0, '0));
        dir_rows.push_back(dir_item(KIND_STATUS, 32'd12345, 32'd0, 16'd0, 16'd0, 1'b0,
                                    1'b1, ST_OK, 32'd12345, PS_NOT_FOUND));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'd2, 32'hABC, 16'd2000, 16'd2000, 1'b0,
                                    1'b1, ST_OK, 32'd2, PS_ACCEPTED));
        dir_rows.push_back(dir_item(KIND_DISARM, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0,
                                    1'b1, ST_OK, 32'd0, PS_IDLE));
        dir_rows.push_back(dir_item(KIND_PULSE, 32'd3, 32'h7FF, 16'd20, 16'd0, 1'b0,
                                    1'b1, ST_NOT_ARMED, 32'd3, PS_ABORTED));
        foreach (dir_rows[i])
            issue_cmd(dir_rows[i]);

        // Random phases, each under its own limit setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    mn = 16'd1;
                    mx = 16'd12;
                    st = 16'd8;
                end
                1:
                begin
                    mn = 16'd0;
                    mx = 16'hFFFF;
                    st = 16'hFFFF;
                end
                2:
                begin
                    mn = 16'd0;
                    mx = 16'd0;
                    st = 16'd0;
                end
                3:
                begin
                    mn = 16'($urandom_range(10, 0));
                    mx = mn + 16'($urandom_range(20, 0));
                    st = 16'($urandom_range(15, 0));
                end
                default:
                begin
                    mn = MIN_HOLD_RST;
                    mx = MAX_HOLD_RST;
                    st = MAX_SETTLE_RST;
                end
            endcase
            program_limits(mn, mx, st);
            // Run phase 1 back to back with no idle cycles; the others idle the channels at random
            gaps_on = (p != 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                    drain_results();
                gen_random_cmd(c);
                issue_cmd(c);
            end
        end

        // Let the last results arrive, then allow for the block's latency
        drain_results();
        repeat (END_WAIT) @(negedge clk);
        if (pending_replies.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_replies.size());
            n_errors++;
        end

        $display("Ran %0d commands under %0d limit settings, %0d register writes.",
                 n_cmds, NUM_PHASES + 1, n_cfg);
        $display("Pulses: %0d started, %0d ran to completion, %0d aborted; %0d mismatches.",
                 n_started, n_completed, n_aborted, n_errors);
        if (n_errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

>>> sim.f
hdl/tbp_pkg.sv
hdl/tbp_ring.sv
hdl/timed_button_pulse_controller.sv
sim/tb_top.sv
